>>> rtl/core/slot_allocator_free_hint_macros.svh
// assertion macros for the slot allocator with lowest-free hint
// no dependencies; included by the modules that carry assertions
`ifndef SLOT_ALLOCATOR_FREE_HINT_MACROS_SVH
`define SLOT_ALLOCATOR_FREE_HINT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled while reset is asserted
`define SAFH_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("safh assertion failed");
// next-cycle implication, disabled while reset is asserted
`define SAFH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("safh assertion failed");
`else
`define SAFH_ASSERT(label, clk, rst_n, ante, cons)
`define SAFH_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/safh_pkg.sv
// shared types and codes for the slot allocator with lowest-free hint
// no dependencies
package safh_pkg;

    typedef logic [1:0] t_action;
    typedef logic [1:0] t_status;

    localparam t_action ACT_ALLOC = 2'd0;
    localparam t_action ACT_FREE  = 2'd1;
    localparam t_action ACT_QUERY = 2'd2;
    localparam t_action ACT_CLEAR = 2'd3;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_FULL    = 2'd1;
    localparam t_status ST_BADSLOT = 2'd2;

    // pointer unit control from the sequencer; load wins over inc
    typedef struct packed {
        logic load;
        logic inc;
    } t_ptr_ctl;

endpackage

>>> rtl/core/safh_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module safh_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/safh_ptr.sv
// shared scan pointer: register, incrementer and bound compare
// depends on safh_pkg
module safh_ptr #(
    parameter int PW = 9
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  safh_pkg::t_ptr_ctl i_ctl,
    input  logic [PW-1:0]     i_load_val,
    input  logic [PW-1:0]     i_limit,
    output logic [PW-1:0]     o_ptr,
    output logic              o_at_limit
);
    import safh_pkg::*;

    logic [PW-1:0] r_ptr;
    logic [PW-1:0] n_ptr;

    always_comb begin
        n_ptr = r_ptr;
        if (i_ctl.load) begin
            n_ptr = i_load_val;
        end else if (i_ctl.inc) begin
            n_ptr = r_ptr + PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else begin
            r_ptr <= n_ptr;
        end
    end

    assign o_ptr      = r_ptr;
    assign o_at_limit = (r_ptr >= i_limit);

endmodule

>>> rtl/core/slot_allocator_free_hint.sv
// top level of the slot allocator with lowest-free hint: sequencer and state
// depends on safh_pkg, safh_ram, safh_ptr and slot_allocator_free_hint_macros.svh
//
// channel  | direction | handshake           | payload
// ---------+-----------+---------------------+---------------------------------------
// command  | in        | start & !busy       | i_action, i_slot_index
// result   | out       | o_done (one cycle)  | o_status, o_granted_slot, o_slots_created
//
// clear, and free or query on an out-of-range handle, finish straight from idle;
//   other frees and queries pass through lookup and check
// allocate scans created slots from the hint: on no free slot it creates one or
//   reports full; on a free slot it takes it and moves the hint past busy slots;
//   each step is one address / registered-read pass through the busy-bit ram
// result strobes the cycle after the item ends; busy is low in that cycle
// i_rst_n is synchronous; the busy-bit ram is not cleared, entries at or above
//   the high-water count are never read before they are written
// the receiver cannot stall; each result is shown for exactly one cycle
`include "slot_allocator_free_hint_macros.svh"

module slot_allocator_free_hint #(
    parameter int SLOTS = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  safh_pkg::t_action  i_action,
    input  logic [7:0]         i_slot_index,
    output logic               o_done,
    output safh_pkg::t_status  o_status,
    output logic [7:0]         o_granted_slot,
    output logic [8:0]         o_slots_created
);
    import safh_pkg::*;

    // widths: ram address, count (holds SLOTS itself), handle compare
    localparam int AW  = $clog2(SLOTS);
    localparam int HWW = $clog2(SLOTS + 1);
    localparam int CW  = (HWW > 8) ? HWW : 8;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN     = 3'd1;  // address a candidate or fall to create
    localparam logic [2:0] S_SCAN_CHK = 3'd2;  // candidate busy bit back from ram
    localparam logic [2:0] S_SKIP     = 3'd3;  // move hint past busy slots
    localparam logic [2:0] S_SKIP_CHK = 3'd4;
    localparam logic [2:0] S_LOOKUP   = 3'd5;  // free/query: address the handle
    localparam logic [2:0] S_CHECK    = 3'd6;  // free/query: busy bit back from ram

    logic [2:0]     r_state, n_state;
    logic [HWW-1:0] r_hw, n_hw;
    logic [HWW-1:0] r_hint, n_hint;
    t_action        r_act, n_act;
    logic           r_done, n_done;
    t_status        r_status, n_status;
    logic [7:0]     r_grant, n_grant;

    // pointer unit interface
    t_ptr_ctl       ptr_ctl;
    logic [HWW-1:0] ptr_load;
    logic [HWW-1:0] ptr;
    logic           ptr_at_hw;

    // busy-bit ram interface
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic           ram_wdata;
    logic           ram_rdata;

    logic           accept;
    logic           idx_out;

    assign accept  = start && !busy;
    // handle at or above the high-water mark names no created slot
    assign idx_out = (CW'(i_slot_index) >= CW'(r_hw));

    safh_ptr #(
        .PW (HWW)
    ) u_ptr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ptr_ctl),
        .i_load_val (ptr_load),
        .i_limit    (r_hw),
        .o_ptr      (ptr),
        .o_at_limit (ptr_at_hw)
    );

    // the read address always follows the scan pointer
    safh_ram #(
        .WIDTH (1),
        .DEPTH (SLOTS)
    ) u_busy_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ptr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_hw      = r_hw;
        n_hint    = r_hint;
        n_act     = r_act;
        n_done    = 1'b0;
        n_status  = r_status;
        n_grant   = r_grant;
        ptr_ctl   = '0;
        ptr_load  = r_hint;
        ram_we    = 1'b0;
        ram_waddr = ptr[AW-1:0];
        ram_wdata = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_act = i_action;
                    unique case (i_action)
                        ACT_ALLOC: begin
                            // start the scan at the hint
                            ptr_ctl.load = 1'b1;
                            ptr_load     = r_hint;
                            n_state      = S_SCAN;
                        end
                        ACT_FREE, ACT_QUERY: begin
                            n_grant = i_slot_index;
                            if (idx_out) begin
                                n_status = ST_BADSLOT;
                                n_done   = 1'b1;
                            end else begin
                                ptr_ctl.load = 1'b1;
                                ptr_load     = HWW'(i_slot_index);
                                n_state      = S_LOOKUP;
                            end
                        end
                        default: begin
                            // clear all: the high-water mark hides every busy bit
                            n_hw     = '0;
                            n_hint   = '0;
                            n_grant  = i_slot_index;
                            n_status = ST_OK;
                            n_done   = 1'b1;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (ptr_at_hw) begin
                    // no free created slot: create one or report full
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                    if (r_hw == HWW'(SLOTS)) begin
                        n_hint   = r_hw;
                        n_status = ST_FULL;
                        n_grant  = '0;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = r_hw[AW-1:0];
                        ram_wdata = 1'b1;
                        n_grant   = 8'(r_hw);
                        n_hw      = r_hw + HWW'(1);
                        n_hint    = r_hw + HWW'(1);
                        n_status  = ST_OK;
                    end
                end else begin
                    n_state = S_SCAN_CHK;
                end
            end

            S_SCAN_CHK: begin
                ptr_ctl.inc = 1'b1;
                if (!ram_rdata) begin
                    // free slot found: take it, then advance the hint
                    ram_we    = 1'b1;
                    ram_wdata = 1'b1;
                    n_grant   = 8'(ptr);
                    n_state   = S_SKIP;
                end else begin
                    n_state = S_SCAN;
                end
            end

            S_SKIP: begin
                if (ptr_at_hw) begin
                    n_hint   = ptr;
                    n_status = ST_OK;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_SKIP_CHK;
                end
            end

            S_SKIP_CHK: begin
                if (ram_rdata) begin
                    ptr_ctl.inc = 1'b1;
                    n_state     = S_SKIP;
                end else begin
                    n_hint   = ptr;
                    n_status = ST_OK;
                    n_done   = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            S_LOOKUP: begin
                n_state = S_CHECK;
            end

            S_CHECK: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                if (!ram_rdata) begin
                    n_status = ST_BADSLOT;
                end else begin
                    n_status = ST_OK;
                    if (r_act == ACT_FREE) begin
                        ram_we    = 1'b1;
                        ram_wdata = 1'b0;
                        if (ptr < r_hint) begin
                            n_hint = ptr;
                        end
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hw    <= '0;
            r_hint  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hw    <= n_hw;
            r_hint  <= n_hint;
            r_done  <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_act    <= n_act;
        r_status <= n_status;
        r_grant  <= n_grant;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_granted_slot  = r_grant;
    assign o_slots_created = 9'(r_hw);

    // a result closes its item, so the sequencer is back in idle
    `SAFH_ASSERT(a_done_idle, i_clk, i_rst_n, o_done, !busy)
    // the hint never passes the high-water mark
    `SAFH_ASSERT(a_hint_le_hw, i_clk, i_rst_n, 1'b1, r_hint <= r_hw)
    // full is only reported once every slot has been created
    `SAFH_ASSERT(a_full_at_cap, i_clk, i_rst_n, o_done && (o_status == ST_FULL),
        r_hw == HWW'(SLOTS))
    // the sequencer leaves idle only on an accepted item
    `SAFH_ASSERT(a_busy_by_start, i_clk, i_rst_n, $rose(busy), $past(start))

endmodule

>>> tb/tb_slot_allocator_free_hint.sv
`timescale 1ns / 1ps
// self-checking testbench for slot_allocator_free_hint: directed and random commands
// depends on safh_pkg and the slot_allocator_free_hint rtl; predicts every reply itself

typedef struct {
    safh_pkg::t_status status;
    logic [7:0]        granted_slot;
    logic [8:0]        slots_created;
} t_slot_reply;

// mirror of the slot pool: predicts each reply and holds the replies still owed
class slot_pool_mirror;
    localparam int SLOT_COUNT = 256;

    bit          in_use[SLOT_COUNT];
    logic [8:0]  high_water;
    logic [8:0]  free_hint;
    t_slot_reply owed_replies[$];
    int          mismatch_count;

    function new();
        in_use         = '{default: 1'b0};
        high_water     = '0;
        free_hint      = '0;
        mismatch_count = 0;
    endfunction

    function int outstanding();
        return owed_replies.size();
    endfunction

    // a random created, in-use slot, or -1 when there is none
    function int pick_live();
        int cands[$];
        for (int i = 0; i < high_water; i++)
            if (in_use[i])
                cands.push_back(i);
        if (cands.size() == 0)
            return -1;
        return cands[$urandom_range(cands.size() - 1)];
    endfunction

    function void record_command(safh_pkg::t_action act, logic [7:0] idx);
        t_slot_reply r;
        bit          hit;
        int          i;
        r.status       = safh_pkg::ST_OK;
        r.granted_slot = idx;
        hit            = 1'b0;
        case (act)
            safh_pkg::ACT_ALLOC: begin
                // scan created slots from the hint up
                i = int'(free_hint);
                while (!hit && i < high_water) begin
                    if (!in_use[i]) begin
                        in_use[i] = 1'b1;
                        free_hint = 9'(i + 1);
                        while (free_hint < high_water && in_use[free_hint])
                            free_hint = free_hint + 9'd1;
                        r.granted_slot = 8'(i);
                        hit = 1'b1;
                    end else begin
                        i++;
                    end
                end
                if (!hit) begin
                    free_hint = high_water;
                    if (high_water < SLOT_COUNT) begin
                        in_use[high_water] = 1'b1;
                        r.granted_slot     = high_water[7:0];
                        high_water         = high_water + 9'd1;
                        free_hint          = high_water;
                    end else begin
                        r.status       = safh_pkg::ST_FULL;
                        r.granted_slot = '0;
                    end
                end
            end
            safh_pkg::ACT_FREE: begin
                if (idx < high_water && in_use[idx]) begin
                    in_use[idx] = 1'b0;
                    if (idx < free_hint)
                        free_hint = 9'(idx);
                end else begin
                    r.status = safh_pkg::ST_BADSLOT;
                end
            end
            safh_pkg::ACT_QUERY: begin
                if (!(idx < high_water && in_use[idx]))
                    r.status = safh_pkg::ST_BADSLOT;
            end
            default: begin
                in_use     = '{default: 1'b0};
                high_water = '0;
                free_hint  = '0;
            end
        endcase
        r.slots_created = high_water;
        owed_replies.push_back(r);
    endfunction

    function void check_reply(safh_pkg::t_status st, logic [7:0] slot, logic [8:0] created);
        t_slot_reply want;
        if (owed_replies.size() == 0) begin
            $error("unexpected reply: status %0d granted_slot %0d slots_created %0d",
                   st, slot, created);
            mismatch_count++;
            return;
        end
        want = owed_replies.pop_front();
        if (st !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, st);
            mismatch_count++;
        end
        if (slot !== want.granted_slot) begin
            $error("granted_slot mismatch: expected %0d, actual %0d", want.granted_slot, slot);
            mismatch_count++;
        end
        if (created !== want.slots_created) begin
            $error("slots_created mismatch: expected %0d, actual %0d",
                   want.slots_created, created);
            mismatch_count++;
        end
    endfunction
endclass

module tb_slot_allocator_free_hint;
    import safh_pkg::*;

    // generous watchdog bound for the whole run
    localparam int CYCLE_LIMIT = 2_000_000;
    // pool size of the block under test
    localparam int POOL_SLOTS  = 256;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_action    i_action;
    logic [7:0] i_slot_index;
    logic       o_done;
    t_status    o_status;
    logic [7:0] o_granted_slot;
    logic [8:0] o_slots_created;

    slot_pool_mirror pool = new();

    int cycle_count = 0;
    bit no_idle     = 1'b0;

    slot_allocator_free_hint uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_slot_index    (i_slot_index),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_granted_slot  (o_granted_slot),
        .o_slots_created (o_slots_created)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // replies are strobed for one cycle and cannot be held off
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1)
            pool.check_reply(o_status, o_granted_slot, o_slots_created);
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // idle cycles before the next item, each cycle idle with a chance of about a third
    function automatic int pick_gap();
        int gap;
        gap = 0;
        if (no_idle)
            return 0;
        while ($urandom_range(99) < 36)
            gap++;
        return gap;
    endfunction

    // present one item and hold it until the block takes it
    task automatic send_command(input t_action act, input logic [7:0] idx);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_action     <= act;
        i_slot_index <= idx;
        // item is taken at the first edge where busy was low
        do @(posedge i_clk); while (busy);
        pool.record_command(act, idx);
    endtask

    // hold off the sender until every reply owed has come back
    task automatic wait_for_drain();
        start <= 1'b0;
        while (pool.outstanding() != 0)
            @(posedge i_clk);
    endtask

    // one random item; the weights are percentages, the rest is noise
    task automatic random_command(input int w_alloc, input int w_free,
                                  input int w_query, input int w_clear);
        int         roll;
        int         live;
        logic [7:0] r_idx;
        t_action    r_act;
        roll  = $urandom_range(99);
        live  = pool.pick_live();
        r_idx = 8'($urandom);
        if (roll < w_alloc) begin
            send_command(ACT_ALLOC, r_idx);
        end else if (roll < w_alloc + w_free) begin
            // mostly frees of a live handle, some stale or out of range
            if (live >= 0 && $urandom_range(9) < 8)
                r_idx = 8'(live);
            send_command(ACT_FREE, r_idx);
        end else if (roll < w_alloc + w_free + w_query) begin
            if (live >= 0 && $urandom_range(9) < 6)
                r_idx = 8'(live);
            send_command(ACT_QUERY, r_idx);
        end else if (roll < w_alloc + w_free + w_query + w_clear) begin
            send_command(ACT_CLEAR, r_idx);
        end else begin
            r_act = t_action'($urandom_range(2, 1));
            send_command(r_act, r_idx);
        end
    endtask

    initial begin
        int n;

        // every input known from time zero
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_action     <= ACT_ALLOC;
        i_slot_index <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: bad handles on an empty pool
        send_command(ACT_QUERY, 8'd0);
        send_command(ACT_FREE, 8'd255);
        // allocate ignores the handle field
        send_command(ACT_ALLOC, 8'd255);
        send_command(ACT_ALLOC, 8'd0);
        send_command(ACT_ALLOC, 8'd0);
        send_command(ACT_ALLOC, 8'd0);
        send_command(ACT_QUERY, 8'd3);
        // free below the hint lowers it
        send_command(ACT_FREE, 8'd1);
        // handle created but not in use
        send_command(ACT_QUERY, 8'd1);
        send_command(ACT_FREE, 8'd1);
        // handle above the high-water count
        send_command(ACT_FREE, 8'd200);
        send_command(ACT_FREE, 8'd3);
        // reuse of a hole, hint steps over busy slots
        send_command(ACT_ALLOC, 8'd0);
        send_command(ACT_ALLOC, 8'd0);
        send_command(ACT_ALLOC, 8'd0);
        send_command(ACT_FREE, 8'd0);
        send_command(ACT_FREE, 8'd2);
        send_command(ACT_ALLOC, 8'd0);
        send_command(ACT_ALLOC, 8'd0);
        // clear with a nonzero handle, then a fresh pool
        send_command(ACT_CLEAR, 8'd255);
        send_command(ACT_QUERY, 8'd0);
        send_command(ACT_FREE, 8'd0);
        send_command(ACT_ALLOC, 8'd128);
        send_command(ACT_QUERY, 8'd0);
        wait_for_drain();

        // growth: mostly allocates until every slot exists
        n = 0;
        while (pool.high_water < POOL_SLOTS) begin
            // long stretch with back-to-back items
            no_idle = (n >= 40 && n < 160);
            random_command(88, 7, 3, 0);
            n++;
        end
        no_idle = 1'b0;
        // pool is full: allocates report no free slot
        repeat (8) send_command(ACT_ALLOC, 8'd0);
        wait_for_drain();

        // churn on a full pool: holes open and close at random
        repeat (180) random_command(35, 35, 18, 1);
        wait_for_drain();

        // small pool after a clear
        send_command(ACT_CLEAR, 8'd0);
        repeat (60) random_command(45, 30, 15, 2);

        start <= 1'b0;
        while (pool.outstanding() != 0)
            @(posedge i_clk);
        // catch any stray reply
        repeat (32) @(posedge i_clk);

        if (pool.mismatch_count == 0 && pool.outstanding() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
